/* src/sosm_pkg.sv */
// Shared types, constants and helpers for the shift-or substring matcher.
// No dependencies; every other file in src imports this package.
package sosm_pkg;

    localparam int MAX_PATTERN = 63;
    localparam int POS_W       = 32;
    localparam int LEN_W       = 6;
    localparam int SV_W        = 64;
    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    typedef logic [MAX_PATTERN-1:0] mask_t;
    typedef logic [SV_W-1:0]        sv_t;
    typedef logic [POS_W-1:0]       pos_t;
    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [BYTE_W-1:0]      byte_t;

    typedef enum logic [1:0] {
        CMD_START_PATTERN = 2'd0,
        CMD_PATTERN_BYTE  = 2'd1,
        CMD_START_TEXT    = 2'd2,
        CMD_TEXT_BYTE     = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH   = 2'd0,
        REG_CASE_INSENSITIVE = 2'd1,
        REG_BACKWARD         = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        cmd_t  command;
        byte_t byte_value;
        len_t  pattern_index;
        pos_t  text_position;
    } item_beat_t;

    typedef struct packed {
        logic found;
        pos_t match_position;
    } result_beat_t;

    typedef struct packed {
        len_t pattern_length;
        logic case_insensitive;
        logic backward;
    } cfg_t;

    typedef struct packed {
        logic  we;
        logic  clear;
        byte_t addr;
        mask_t data;
    } mask_wr_t;

    localparam byte_t UPPER_A     = 8'h41;
    localparam byte_t UPPER_Z     = 8'h5A;
    localparam byte_t CASE_OFFSET = 8'h20;
    localparam sv_t   SV_RESET    = ~sv_t'(1);
    localparam mask_t MASK_ONES   = '1;

    function automatic byte_t fold_byte(byte_t b, logic ci);
        byte_t r;
        r = b;
        if (ci && (b >= UPPER_A) && (b <= UPPER_Z))
        begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

/* src/sosm_mask_table.sv */
// Per-byte pattern mask table: 256 x 63 memory with per-entry valid bits.
// Depends on sosm_pkg. Invalid entries read as all ones; registered read.
module sosm_mask_table (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  sosm_pkg::byte_t  rd_addr,
    input  sosm_pkg::mask_wr_t wr,
    output sosm_pkg::mask_t  rd_mask
);
    import sosm_pkg::*;

    mask_t                  mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    mask_t                  rd_data_reg;
    logic                   rd_valid_reg;
    logic                   byp_hit_reg;
    mask_t                  byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            byp_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr.clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr] && !wr.clear;
                byp_hit_reg  <= wr.we && (wr.addr == rd_addr);
            end
        end
    end

    // write-first bypass for a write landing on the edge of the read
    assign rd_mask = byp_hit_reg  ? byp_data_reg :
                     rd_valid_reg ? rd_data_reg  : MASK_ONES;

endmodule

/* src/sosm_core.sv */
// Search stage: item register, shift-or update, match latch, result register.
// Depends on sosm_pkg; reads and writes the mask table through its ports.
module sosm_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sosm_pkg::cfg_t         cfg,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  sosm_pkg::item_beat_t   item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output sosm_pkg::result_beat_t result,
    output logic                   rd_en,
    output sosm_pkg::byte_t        rd_addr,
    input  sosm_pkg::mask_t        rd_mask,
    output sosm_pkg::mask_wr_t     wr
);
    import sosm_pkg::*;

    logic         s1_valid_reg, s1_valid_next;
    item_beat_t   s1_item_reg;
    byte_t        s1_byte_reg;
    sv_t          sv_reg, sv_next;
    logic         found_reg, found_next;
    pos_t         fpos_reg, fpos_next;
    logic         out_valid_reg, out_valid_next;
    result_beat_t out_reg, out_next;

    logic         advance;
    sv_t          sv_shift;
    len_t         bit_sel;
    logic         idx_ok;

    assign advance    = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || advance;
    assign rd_en      = item_valid && item_ready;
    assign rd_addr    = fold_byte(item.byte_value, cfg.case_insensitive);

    assign sv_shift = (sv_reg | {1'b1, rd_mask}) << 1;
    assign bit_sel  = cfg.backward ? (cfg.pattern_length - len_t'(1) - s1_item_reg.pattern_index)
                                   : s1_item_reg.pattern_index;
    assign idx_ok   = (s1_item_reg.pattern_index < cfg.pattern_length)
                   && (s1_item_reg.pattern_index < len_t'(MAX_PATTERN));

    always_comb
    begin
        sv_next    = sv_reg;
        found_next = found_reg;
        fpos_next  = fpos_reg;
        wr.we      = 1'b0;
        wr.clear   = 1'b0;
        wr.addr    = s1_byte_reg;
        wr.data    = rd_mask & ~(mask_t'(1) << bit_sel);
        if (advance)
        begin
            unique case (s1_item_reg.command)
                CMD_START_PATTERN:
                begin
                    wr.clear = 1'b1;
                end
                CMD_PATTERN_BYTE:
                begin
                    wr.we = idx_ok;
                end
                CMD_START_TEXT:
                begin
                    sv_next    = SV_RESET;
                    found_next = (cfg.pattern_length == '0);
                    fpos_next  = '0;
                end
                CMD_TEXT_BYTE:
                begin
                    sv_next = sv_shift;
                    if (!found_reg)
                    begin
                        if (cfg.pattern_length == '0)
                        begin
                            found_next = 1'b1;
                            fpos_next  = '0;
                        end
                        else if ((cfg.pattern_length <= len_t'(MAX_PATTERN))
                                 && !sv_shift[cfg.pattern_length])
                        begin
                            found_next = 1'b1;
                            fpos_next  = cfg.backward ? s1_item_reg.text_position
                                       : s1_item_reg.text_position
                                         - pos_t'(cfg.pattern_length) + pos_t'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next  = rd_en || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !result_ready);
        out_next       = out_reg;
        if (advance)
        begin
            out_next.found          = found_next || (cfg.pattern_length == '0);
            out_next.match_position = found_next ? fpos_next : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sv_reg        <= SV_RESET;
            found_reg     <= 1'b0;
            fpos_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            sv_reg        <= sv_next;
            found_reg     <= found_next;
            fpos_reg      <= fpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_item_reg <= item;
            s1_byte_reg <= rd_addr;
        end
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* src/shift_or_substring_matcher_unit.sv */
// Top level of the shift-or substring matcher: config registers, core, mask table.
// Depends on sosm_pkg, sosm_core and sosm_mask_table.
//
// Shift-or exact substring search. Load a pattern with a start-pattern beat and
// one beat per pattern byte, then send start-text and the text bytes. Every item
// beat yields exactly one result beat carrying the found flag and the start
// position of the first match since start text. One item is taken per clock while
// the result register is free or being taken; item and mask are registered first,
// then the result. The rate is set by the mask table's single read port, read as
// the item is taken, and the OR-shift of the 64-bit search vector. Config writes
// are always ready and must be issued only while the block is idle.
module shift_or_substring_matcher_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  sosm_pkg::item_beat_t                item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output sosm_pkg::result_beat_t              result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sosm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sosm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sosm_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     rd_en;
    byte_t    rd_addr;
    mask_t    rd_mask;
    mask_wr_t wr;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH:   cfg_next.pattern_length   = cfg_data[LEN_W-1:0];
                REG_CASE_INSENSITIVE: cfg_next.case_insensitive = cfg_data[0];
                REG_BACKWARD:         cfg_next.backward         = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sosm_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_mask      (rd_mask),
        .wr           (wr)
    );

    sosm_mask_table u_mask_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd_mask (rd_mask)
    );

endmodule

/* src/sosm_checker.sv */
// Port-level checks for the shift-or substring matcher, bound to the top level.
// Depends on sosm_pkg and shift_or_substring_matcher_unit.
module sosm_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input sosm_pkg::result_beat_t result
);
    import sosm_pkg::*;

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.match_position == '0)
        else $error("match position nonzero without found");

    // empty output side never back-pressures the item side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("item side stalled with output empty");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result beat without a matching item beat");

endmodule

bind shift_or_substring_matcher_unit sosm_checker u_checker (.*);

/* dv/sosm_match_monitor.sv */
// Watches the item, result and config channels of the shift-or matcher, predicts
// each result beat and compares it with what the block returns.
// Depends on sosm_pkg.
module sosm_match_monitor
    import sosm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  item_beat_t            item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_beat_t          result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    mask_t        char_masks [TABLE_DEPTH];
    sv_t          search_bits;
    logic         match_seen;
    pos_t         match_start;
    len_t         pat_len;
    logic         fold_case;
    logic         reverse_scan;
    result_beat_t results_due [$];
    result_beat_t want;
    int           beat_count;

    initial
    begin
        errors = 0;
        pending = 0;
        beat_count = 0;
    end

    function automatic byte_t fold_char(byte_t b);
        if (fold_case && b >= UPPER_A && b <= UPPER_Z)
        begin
            return b + 8'h20;
        end
        return b;
    endfunction

    // Advance the search state by one item and return the result beat it yields.
    function automatic result_beat_t search_step(item_beat_t it);
        byte_t        ch;
        int unsigned  bit_sel;
        result_beat_t r;
        ch = fold_char(it.byte_value);
        case (it.command)
            CMD_START_PATTERN:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    char_masks[i] = '1;
                end
            end
            CMD_PATTERN_BYTE:
            begin
                if (it.pattern_index < pat_len && it.pattern_index < MAX_PATTERN)
                begin
                    bit_sel = reverse_scan ? pat_len - 1 - it.pattern_index
                                           : it.pattern_index;
                    char_masks[ch][bit_sel] = 1'b0;
                end
            end
            CMD_START_TEXT:
            begin
                search_bits = ~sv_t'(1);
                match_seen = (pat_len == 0);
                match_start = '0;
            end
            default:
            begin
                search_bits = (search_bits | {1'b1, char_masks[ch]}) << 1;
                if (!match_seen)
                begin
                    if (pat_len == 0)
                    begin
                        match_seen = 1'b1;
                        match_start = '0;
                    end
                    else if (!search_bits[pat_len])
                    begin
                        match_seen = 1'b1;
                        match_start = reverse_scan ? it.text_position
                                                   : pos_t'(it.text_position - pat_len + 1);
                    end
                end
            end
        endcase
        r.found = match_seen ? 1'b1 : (pat_len == 0);
        r.match_position = match_seen ? match_start : '0;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("result beat %0d: %s", beat_count, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                char_masks[i] = '1;
            end
            search_bits = ~sv_t'(1);
            match_seen = 1'b0;
            match_start = '0;
            pat_len = '0;
            fold_case = 1'b0;
            reverse_scan = 1'b0;
            results_due.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PATTERN_LENGTH:   pat_len = cfg_data;
                    REG_CASE_INSENSITIVE: fold_case = cfg_data[0];
                    REG_BACKWARD:         reverse_scan = cfg_data[0];
                    default:              ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                results_due.push_back(search_step(item));
            end
            if (result_valid && result_ready)
            begin
                if (results_due.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected beat found=%0b pos=%0h",
                                            result.found, result.match_position));
                end
                else
                begin
                    want = results_due.pop_front();
                    if (result.found !== want.found)
                    begin
                        flag_mismatch($sformatf("found %0b, want %0b",
                                                result.found, want.found));
                    end
                    if (result.match_position !== want.match_position)
                    begin
                        flag_mismatch($sformatf("match_position %0h, want %0h",
                                                result.match_position,
                                                want.match_position));
                    end
                end
                beat_count++;
            end
            pending = results_due.size();
        end
    end

endmodule

/* dv/shift_or_substring_matcher_unit_tb.sv */
// Testbench top for the shift-or substring matcher: clock, reset, directed and
// random pattern/text stimulus with random gaps and stalls, verdict.
// Depends on sosm_pkg, shift_or_substring_matcher_unit and sosm_match_monitor.
module shift_or_substring_matcher_unit_tb;
    import sosm_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1400;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_beat_t            item;
    logic                  result_valid;
    logic                  result_ready;
    result_beat_t          result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    cycles;
    int                    gap_pct;
    int                    stall_pct;
    int                    sent;
    byte_t                 pattern_bytes [MAX_PATTERN];
    byte_t                 text_bytes [160];

    shift_or_substring_matcher_unit i_dut (.*);

    sosm_match_monitor i_monitor (.*);

    initial
    begin
        clk = 1'b0;
        cycles = 0;
        gap_pct = 0;
        stall_pct = 0;
        sent = 0;
    end

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("shift_or_substring_matcher_unit_tb: errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic byte_t pick_char();
        case ($urandom_range(9))
            0:             return byte_t'($urandom_range(255));
            1, 2, 3, 4, 5: return byte_t'(8'h61 + $urandom_range(2));
            default:       return byte_t'(8'h41 + $urandom_range(2));
        endcase
    endfunction

    task automatic push_item(input cmd_t c, input byte_t b, input int unsigned idx,
                             input pos_t p);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        item_valid <= 1'b1;
        item <= '{command: c, byte_value: b, pattern_index: len_t'(idx), text_position: p};
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        sent++;
    endtask

    task automatic put_reg(input cfg_reg_t r, input int unsigned v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= CFG_DATA_W'(v);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Registers change only with the block drained.
    task automatic write_regs(input int unsigned len, input bit ci, input bit bw);
        item_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        put_reg(REG_PATTERN_LENGTH, len);
        put_reg(REG_CASE_INSENSITIVE, ci);
        put_reg(REG_BACKWARD, bw);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned len;
        int unsigned tl;
        int unsigned off;
        int unsigned j;
        int unsigned k;
        int          phase;
        bit          ci;
        bit          bw;
        bit          rev;
        pos_t        base;
        byte_t       b;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // empty pattern at reset, text before any start text
        push_item(CMD_TEXT_BYTE, "q", 0, 32'd5);
        push_item(CMD_START_TEXT, 8'h00, 0, 32'd0);

        write_regs(3, 1'b1, 1'b0);
        push_item(CMD_START_PATTERN, 8'hFF, 63, 32'hFFFF_FFFF);
        push_item(CMD_PATTERN_BYTE, "A", 0, 32'd0);
        push_item(CMD_PATTERN_BYTE, "b", 1, 32'd0);
        push_item(CMD_PATTERN_BYTE, "C", 2, 32'd0);
        push_item(CMD_PATTERN_BYTE, "z", 3, 32'd0);
        push_item(CMD_PATTERN_BYTE, "z", 63, 32'd0);
        push_item(CMD_START_TEXT, 8'h00, 0, 32'd0);
        push_item(CMD_TEXT_BYTE, "x", 0, 32'd0);
        push_item(CMD_TEXT_BYTE, "a", 0, 32'd1);
        push_item(CMD_TEXT_BYTE, "B", 0, 32'd2);
        push_item(CMD_TEXT_BYTE, "c", 0, 32'd3);
        // match position wraps below zero
        push_item(CMD_START_TEXT, 8'hFF, 63, 32'hFFFF_FFFF);
        push_item(CMD_TEXT_BYTE, "a", 0, 32'd0);
        push_item(CMD_TEXT_BYTE, "b", 0, 32'd0);
        push_item(CMD_TEXT_BYTE, "C", 0, 32'd1);
        push_item(CMD_TEXT_BYTE, 8'h00, 0, 32'd0);
        push_item(CMD_TEXT_BYTE, 8'hFF, 63, 32'hFFFF_FFFF);
        // table cleared, no match
        push_item(CMD_START_PATTERN, 8'h00, 0, 32'd0);
        push_item(CMD_START_TEXT, 8'h00, 0, 32'd0);
        push_item(CMD_TEXT_BYTE, "a", 0, 32'd0);

        write_regs(2, 1'b0, 1'b1);
        push_item(CMD_START_PATTERN, 8'h00, 0, 32'd0);
        push_item(CMD_PATTERN_BYTE, "a", 0, 32'd0);
        push_item(CMD_PATTERN_BYTE, "B", 1, 32'd0);
        push_item(CMD_START_TEXT, 8'h00, 0, 32'd0);
        push_item(CMD_TEXT_BYTE, "B", 0, 32'd2);
        push_item(CMD_TEXT_BYTE, "a", 0, 32'd1);
        push_item(CMD_TEXT_BYTE, "x", 0, 32'd0);

        for (phase = 0; sent < RANDOM_ITEMS + 30; phase++)
        begin
            case (phase)
                0:       begin len = 63; ci = 1'b1; bw = 1'b1; end
                1:       begin len = 1;  ci = 1'b0; bw = 1'b0; end
                2:       begin len = 0;  ci = 1'b1; bw = 1'b0; end
                3:       begin len = 63; ci = 1'b0; bw = 1'b0; end
                default:
                begin
                    len = ($urandom_range(5) == 0) ? $urandom_range(13, 63)
                                                   : $urandom_range(1, 12);
                    if ($urandom_range(15) == 0)
                    begin
                        len = 0;
                    end
                    ci = $urandom_range(1);
                    bw = $urandom_range(1);
                end
            endcase
            case (phase % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 53; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 53; end
                default: begin gap_pct = 6;  stall_pct = 6;  end
            endcase
            write_regs(len, ci, bw);

            push_item(CMD_START_PATTERN, byte_t'($urandom()), $urandom_range(63), $urandom());
            for (int i = 0; i < len; i++)
            begin
                pattern_bytes[i] = pick_char();
            end
            rev = $urandom_range(1);
            for (int i = 0; i < len; i++)
            begin
                j = rev ? len - 1 - i : i;
                push_item(CMD_PATTERN_BYTE, pattern_bytes[j], j, $urandom());
            end
            if ($urandom_range(2) == 0)
            begin
                push_item(CMD_PATTERN_BYTE, pick_char(), $urandom_range(len, 63), $urandom());
            end

            repeat ($urandom_range(2, 5))
            begin
                tl = len + $urandom_range(12);
                for (int i = 0; i < tl; i++)
                begin
                    text_bytes[i] = pick_char();
                end
                if (len > 0 && $urandom_range(9) < 7)
                begin
                    off = $urandom_range(tl - len);
                    for (int i = 0; i < len; i++)
                    begin
                        b = pattern_bytes[i];
                        if (ci && $urandom_range(1) &&
                            ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")))
                        begin
                            b = b ^ 8'h20;
                        end
                        text_bytes[off + i] = b;
                    end
                end
                case ($urandom_range(5))
                    0:       base = '0;
                    1:       base = 32'hFFFF_FFF0 + $urandom_range(15);
                    default: base = $urandom();
                endcase
                if ($urandom_range(5) != 0)
                begin
                    push_item(CMD_START_TEXT, byte_t'($urandom()), $urandom_range(63),
                              $urandom());
                end
                for (int i = 0; i < tl; i++)
                begin
                    k = bw ? tl - 1 - i : i;
                    push_item(CMD_TEXT_BYTE, text_bytes[k], $urandom_range(63), base + k);
                    if ($urandom_range(39) == 0)
                    begin
                        push_item(cmd_t'($urandom_range(3)), byte_t'($urandom()),
                                  $urandom_range(63), $urandom());
                    end
                end
            end
        end

        item_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
        begin
            $display("shift_or_substring_matcher_unit_tb: clean");
        end
        else
        begin
            $display("shift_or_substring_matcher_unit_tb: errors");
        end
        $finish;
    end

endmodule
